@@ hw/rtl/lgps_pkg.sv @@
`timescale 1ns / 1ps
// Package for the linear gradient pixel shader: payload and configuration
// structs, register index codes, tile modes and fixed-point constants.
// No dependencies.
package lgps_pkg;

    // Field widths of the transaction payloads and registers.
    localparam int IN_COORD_W = 12;
    localparam int GAIN_W     = 40;
    localparam int COLOR_W    = 32;
    localparam int ALPHA_W    = 9;
    localparam int MODE_W     = 2;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 24;

    // Interpolation fraction width; T = 2^LERP_BITS means the end color.
    localparam int LERP_BITS = 16;

    // Configuration port geometry: 64-bit data, registers at 8*i.
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    // Opacity after reset: fully opaque.
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd256;

    // Register indexes in address order.
    typedef enum logic [2:0] {
        REG_TILE_MODE    = 3'd0,
        REG_GAIN_X       = 3'd1,
        REG_GAIN_Y       = 3'd2,
        REG_OFFSET_W     = 3'd3,
        REG_COLOR_START  = 3'd4,
        REG_COLOR_END    = 3'd5,
        REG_SHADER_ALPHA = 3'd6
    } reg_idx_t;

    // Tile modes; the unused code behaves as mirror.
    typedef enum logic [MODE_W-1:0] {
        TILE_CLAMP  = 2'd0,
        TILE_REPEAT = 2'd1,
        TILE_MIRROR = 2'd2
    } tile_mode_t;

    // Input transaction.
    typedef struct packed {
        logic [IN_COORD_W-1:0] pixel_x;
        logic [IN_COORD_W-1:0] pixel_y;
        logic                  span_end;
    } pix_in_t;

    // Output transaction.
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_argb;
        logic               span_end_out;
    } pix_out_t;

    // Configuration register set handed to the shading pipeline.
    typedef struct packed {
        logic [MODE_W-1:0]         tile_mode;
        logic signed [GAIN_W-1:0]  gain_x;
        logic signed [GAIN_W-1:0]  gain_y;
        logic signed [GAIN_W-1:0]  offset_w;
        logic [COLOR_W-1:0]        color_start;
        logic [COLOR_W-1:0]        color_end;
        logic [ALPHA_W-1:0]        shader_alpha;
    } cfg_t;

endpackage

@@ hw/rtl/lgps_core.sv @@
`timescale 1ns / 1ps
// Seven-stage shading pipeline of the linear gradient pixel shader.
// Depends on lgps_pkg for payload, configuration and constant definitions.
module lgps_core
    import lgps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  pix_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output pix_out_t out_data
);

    // Stage count and datapath widths.
    localparam int NST   = 7;
    localparam int UB    = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int XW    = UB + 2;
    localparam int PW    = GAIN_W + XW;
    localparam int SW    = PW + 2;
    localparam int WW    = SW - 1;
    localparam int TW    = FRAC_BITS + 1;
    localparam int T16W  = LERP_BITS + 1;
    localparam int CHW   = 8 + LERP_BITS;
    localparam int ASW   = CHW + ALPHA_W;
    localparam int PRW   = CHW + ASW;
    localparam int ALPHA_SHIFT = LERP_BITS + 8;
    localparam int SCALE_SHIFT = 2 * LERP_BITS + 8;
    localparam int QW    = PRW - SCALE_SHIFT;
    localparam int AHW   = ASW - ALPHA_SHIFT;
    localparam int RECIP_SHIFT = 23;
    localparam logic [15:0]     RECIP     = 16'h8081;
    localparam logic [QW-1:0]   SAT_LIMIT = QW'(256 * 255);
    localparam logic [T16W-1:0] T_ONE     = T16W'(1) << LERP_BITS;
    localparam logic [TW-1:0]   W_ONE     = TW'(1) << FRAC_BITS;
    localparam logic [TW:0]     W_TWO     = (TW + 1)'(1) << (FRAC_BITS + 1);

    // Per-stage valid bits and load enables.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;
    logic [NST-1:0] span_reg;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // The span marker travels beside the data.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            span_reg[0] <= in_data.span_end;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (en[k])
            begin
                span_reg[k] <= span_reg[k-1];
            end
        end
    end

    // Stage 1: doubled pixel centers times the gradient gains.
    logic signed [XW-1:0] x2;
    logic signed [XW-1:0] y2;
    logic signed [PW-1:0] px_next;
    logic signed [PW-1:0] py_next;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;

    always_comb
    begin
        x2      = $signed({1'b0, in_data.pixel_x[UB-1:0], 1'b1});
        y2      = $signed({1'b0, in_data.pixel_y[UB-1:0], 1'b1});
        px_next = PW'(cfg.gain_x) * PW'(x2);
        py_next = PW'(cfg.gain_y) * PW'(y2);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    // Stage 2: sum with the doubled offset, then halve with floor.
    logic signed [SW-1:0] w2;
    logic signed [WW-1:0] w_next;
    logic signed [WW-1:0] w_reg;

    always_comb
    begin
        w2 = SW'(px_reg) + SW'(py_reg)
           + $signed({{(SW - GAIN_W - 1){cfg.offset_w[GAIN_W-1]}}, cfg.offset_w, 1'b0});
        w_next = w2[SW-1:1];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            w_reg <= w_next;
        end
    end

    // Stage 3: tile mode folds w into t in [0, 1], then drop to 16 fraction bits.
    logic [TW-1:0]   t_val;
    logic [TW-1:0]   m_val;
    logic [TW:0]     m_ref;
    logic [T16W-1:0] t16_reg;

    always_comb
    begin
        m_val = w_reg[TW-1:0];
        m_ref = W_TWO - {1'b0, m_val};
        case (cfg.tile_mode)
            TILE_CLAMP:
            begin
                if (w_reg[WW-1] || (w_reg == '0))
                begin
                    t_val = '0;
                end
                else if (|w_reg[WW-2:FRAC_BITS])
                begin
                    t_val = W_ONE;
                end
                else
                begin
                    t_val = m_val;
                end
            end
            TILE_REPEAT:
            begin
                t_val = {1'b0, w_reg[FRAC_BITS-1:0]};
            end
            default:
            begin
                // Mirror: the upper half of each period reflects back.
                t_val = m_val[FRAC_BITS] ? m_ref[TW-1:0] : m_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            t16_reg <= t_val[FRAC_BITS -: T16W];
        end
    end

    // Stage 4: per-channel lerp, scaled by 2^16.
    logic [CHW-1:0] ch_next [4];
    logic [CHW-1:0] ch_reg  [4];
    logic [CHW:0]   ch_sum  [4];
    logic [T16W-1:0] t_inv;

    always_comb
    begin
        t_inv = T_ONE - t16_reg;
        for (int k = 0; k < 4; k++)
        begin
            ch_sum[k]  = (CHW + 1)'(cfg.color_start[8*k +: 8]) * (CHW + 1)'(t_inv)
                       + (CHW + 1)'(cfg.color_end[8*k +: 8]) * (CHW + 1)'(t16_reg);
            ch_next[k] = ch_sum[k][CHW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int k = 0; k < 4; k++)
            begin
                ch_reg[k] <= ch_next[k];
            end
        end
    end

    // Stage 5: alpha channel times the shader opacity.
    logic [ASW-1:0] as_next;
    logic [ASW-1:0] as_reg;
    logic [CHW-1:0] col_reg [3];

    assign as_next = ASW'(ch_reg[3]) * ASW'(cfg.shader_alpha);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            as_reg <= as_next;
            for (int k = 0; k < 3; k++)
            begin
                col_reg[k] <= ch_reg[k];
            end
        end
    end

    // Stage 6: premultiply colors and saturate alpha.
    logic [PRW-1:0] prod    [3];
    logic [QW-1:0]  q_reg   [3];
    logic [AHW-1:0] a_hi;
    logic [7:0]     oa_next;
    logic [7:0]     oa_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = PRW'(col_reg[k]) * PRW'(as_reg);
        end
        a_hi    = as_reg[ASW-1:ALPHA_SHIFT];
        oa_next = (a_hi > AHW'(255)) ? 8'hFF : a_hi[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            oa_reg <= oa_next;
            for (int k = 0; k < 3; k++)
            begin
                q_reg[k] <= prod[k][PRW-1:SCALE_SHIFT];
            end
        end
    end

    // Stage 7: divide by 255 through a reciprocal, saturate, output register.
    logic [31:0] recip_prod [3];
    logic [7:0]  oc_next    [3];
    logic [31:0] argb_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            recip_prod[k] = 32'(q_reg[k][15:0]) * 32'(RECIP);
            oc_next[k]    = (q_reg[k] >= SAT_LIMIT) ? 8'hFF
                          : recip_prod[k][RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            argb_reg <= {oa_reg, oc_next[2], oc_next[1], oc_next[0]};
        end
    end

    assign out_valid             = v_reg[NST-1];
    assign out_data.pixel_argb   = argb_reg;
    assign out_data.span_end_out = span_reg[NST-1];

    // The input side stalls only when every stage holds a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&v_reg))
        else $error("input stalled while a pipeline stage was empty");

    // The folded parameter never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> (t16_reg <= T_ONE))
        else $error("gradient parameter above one");

    // Clamp pins negative w to the start color.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en[2] && v_reg[1] && (cfg.tile_mode == TILE_CLAMP) && w_reg[WW-1])
        |=> (t16_reg == '0))
        else $error("clamp did not pin negative w to zero");

endmodule

@@ hw/rtl/linear_gradient_pixel_shader.sv @@
`timescale 1ns / 1ps
// Top level of the linear gradient pixel shader: configuration registers
// behind the APB-style port, and the lgps_core pipeline. Depends on lgps_pkg.
//
//  Channel  | Signals                               | Transaction
//  ---------+---------------------------------------+------------------------------
//  input    | in_valid, in_stall, in_data           | valid && !stall: one pixel
//  output   | out_valid, out_stall, out_data        | valid && !stall: one shade
//  config   | psel, penable, pwrite, paddr, pwdata, | write at psel && penable &&
//           | prdata, pready                        | pwrite && pready, at 8*index
//
// One pixel per cycle sustained while the output is not stalled. The seven pipeline
// stages load in order, the first on the accepting edge, and out_valid rises when
// the pixel reaches the last stage, the output register.
// Reset clears the valid bits and loads the register reset values.
// A stalled output holds its pixel; stages behind it keep filling empty
// slots, and the input stalls only when all seven stages are full.
module linear_gradient_pixel_shader
    import lgps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pix_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pix_out_t              out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Register values after reset: all zero except a fully opaque shader.
    localparam cfg_t CFG_RESET = '{
        tile_mode:    '0,
        gain_x:       '0,
        gain_y:       '0,
        offset_w:     '0,
        color_start:  '0,
        color_end:    '0,
        shader_alpha: ALPHA_RESET
    };

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register write decode; an index past the list is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TILE_MODE:    cfg_next.tile_mode    = pwdata[MODE_W-1:0];
                REG_GAIN_X:       cfg_next.gain_x       = pwdata[GAIN_W-1:0];
                REG_GAIN_Y:       cfg_next.gain_y       = pwdata[GAIN_W-1:0];
                REG_OFFSET_W:     cfg_next.offset_w     = pwdata[GAIN_W-1:0];
                REG_COLOR_START:  cfg_next.color_start  = pwdata[COLOR_W-1:0];
                REG_COLOR_END:    cfg_next.color_end    = pwdata[COLOR_W-1:0];
                REG_SHADER_ALPHA: cfg_next.shader_alpha = pwdata[ALPHA_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back, zero extended.
    always_comb
    begin
        case (reg_idx)
            REG_TILE_MODE:    prdata = APB_DATA_W'(cfg_reg.tile_mode);
            REG_GAIN_X:       prdata = APB_DATA_W'($unsigned(cfg_reg.gain_x));
            REG_GAIN_Y:       prdata = APB_DATA_W'($unsigned(cfg_reg.gain_y));
            REG_OFFSET_W:     prdata = APB_DATA_W'($unsigned(cfg_reg.offset_w));
            REG_COLOR_START:  prdata = APB_DATA_W'(cfg_reg.color_start);
            REG_COLOR_END:    prdata = APB_DATA_W'(cfg_reg.color_end);
            REG_SHADER_ALPHA: prdata = APB_DATA_W'(cfg_reg.shader_alpha);
            default:          prdata = '0;
        endcase
    end

    // Shading pipeline.
    lgps_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
